// ----- rtl/bbq_pkg.sv -----
`default_nettype none
package bbq_pkg;

  // fixed point format of positions, vectors and sizes
  localparam int FRAC_BITS    = 16;
  // output positions are scaled by 2^OUT_MUL_BITS (x64)
  localparam int OUT_MUL_BITS = 6;
  localparam int OUT_SHIFT    = FRAC_BITS - OUT_MUL_BITS;

  localparam int COORD_W  = 32;
  localparam int SIZE_W   = 31;
  localparam int COLOUR_W = 32;
  localparam int OUT_W    = 16;
  localparam int TEX_W    = 11;
  localparam int IDX_W    = 4;
  localparam int VCNT_W   = 3;

  // half size: scale * size, then floor shift and clamp
  localparam int SIZE_PROD_W = COORD_W + SIZE_W;
  localparam int HALF_SHIFT  = FRAC_BITS + 1;
  localparam int HALF_W      = 31;
  // extent: half size * |vector component|
  localparam int EXT_PROD_W  = HALF_W + COORD_W;
  localparam int EXT_W       = EXT_PROD_W - FRAC_BITS + 1;
  // corner position: centre +- a +- b
  localparam int POS_W       = EXT_W + 2;

  localparam logic [TEX_W-1:0]  TEX_ONE   = TEX_W'(1024);
  localparam logic [VCNT_W-1:0] LAST_QUAD = VCNT_W'(3);
  localparam logic [VCNT_W-1:0] LAST_TRI  = VCNT_W'(5);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_RIGHT_X   = 4'd0,
    REG_RIGHT_Y   = 4'd1,
    REG_RIGHT_Z   = 4'd2,
    REG_UP_X      = 4'd3,
    REG_UP_Y      = 4'd4,
    REG_UP_Z      = 4'd5,
    REG_SIZE_SCALE = 4'd6,
    REG_QUAD_MODE = 4'd7
  } reg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EXT_W-1:0]   ext_t;
  typedef logic signed [OUT_W-1:0]   vout_t;

  typedef struct packed {
    coord_t [2:0]         right;
    coord_t [2:0]         up;
    logic [COORD_W-1:0]   scale;
    logic                 quad_mode;
  } cfg_t;

  // per sprite payload carried down the pipeline
  typedef struct packed {
    coord_t [2:0]         ctr;
    logic [COLOUR_W-1:0]  colour;
    logic                 last;
  } sprite_t;

  typedef struct packed {
    sprite_t      spr;
    ext_t [2:0]   a;
    ext_t [2:0]   b;
  } extent_t;

  // four corners, three components each, already in output format
  typedef struct packed {
    sprite_t           spr;
    vout_t [3:0][2:0]  pos;
  } quad_t;

  typedef struct packed {
    vout_t                x;
    vout_t                y;
    vout_t                z;
    logic [TEX_W-1:0]     tex_s;
    logic [TEX_W-1:0]     tex_t;
    logic [COLOUR_W-1:0]  colour;
    logic [1:0]           corner;
    logic                 sprite_done;
    logic                 batch_done;
  } vert_t;

  // triangle list order: 0,1,2,0,2,3
  function automatic logic [1:0] tri_corner(input logic [VCNT_W-1:0] k);
    logic [1:0] cn;
    unique case (k)
      3'd0:    cn = 2'd0;
      3'd1:    cn = 2'd1;
      3'd2:    cn = 2'd2;
      3'd3:    cn = 2'd0;
      3'd4:    cn = 2'd2;
      3'd5:    cn = 2'd3;
      default: cn = 2'd0;
    endcase
    return cn;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/billboard_quad_vertex_expander.sv -----
`default_nettype none
// Billboard sprite expander. A sprite transfer happens on a clock edge with
// start high and busy low; every sprite becomes four vertices (quad mode) or
// six (triangle list 0,1,2,0,2,3), one per cycle on the out_ ports, each
// marked by out_valid for exactly one cycle. Sprites are taken every cycle
// until the six arithmetic stages and the vertex sequencer are all full;
// the sustained sprite rate is set by the vertex sequencer sending one vertex
// per cycle. busy then rises and falls as the pipeline drains, so the
// receiver never has to hold off a vertex. Write the configuration registers
// only while no sprite is in flight; indexes above 7 are ignored.
module billboard_quad_vertex_expander import bbq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [IDX_W-1:0]     cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data,
  // sprite input
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [COORD_W-1:0]   in_center_x,
  input  wire logic [COORD_W-1:0]   in_center_y,
  input  wire logic [COORD_W-1:0]   in_center_z,
  input  wire logic [SIZE_W-1:0]    in_sprite_width,
  input  wire logic [SIZE_W-1:0]    in_sprite_height,
  input  wire logic [COLOUR_W-1:0]  in_sprite_colour,
  input  wire logic                 in_last_sprite,
  // vertex output
  output logic                      out_valid,
  output logic signed [OUT_W-1:0]   out_vert_x,
  output logic signed [OUT_W-1:0]   out_vert_y,
  output logic signed [OUT_W-1:0]   out_vert_z,
  output logic [TEX_W-1:0]          out_tex_s,
  output logic [TEX_W-1:0]          out_tex_t,
  output logic [COLOUR_W-1:0]       out_vert_colour,
  output logic [1:0]                out_corner,
  output logic                      out_sprite_done,
  output logic                      out_batch_done
);

  cfg_t    cfg_r;
  sprite_t in_spr;
  logic    in_ready;
  logic    ext_valid, ext_ready;
  extent_t ext;
  logic    quad_valid, quad_ready;
  quad_t   quad;
  vert_t   vert;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.right[0]  <= coord_t'(1 << FRAC_BITS);
      cfg_r.right[1]  <= '0;
      cfg_r.right[2]  <= '0;
      cfg_r.up[0]     <= '0;
      cfg_r.up[1]     <= coord_t'(1 << FRAC_BITS);
      cfg_r.up[2]     <= '0;
      cfg_r.scale     <= COORD_W'(1 << FRAC_BITS);
      cfg_r.quad_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RIGHT_X:    cfg_r.right[0]  <= cfg_data;
        REG_RIGHT_Y:    cfg_r.right[1]  <= cfg_data;
        REG_RIGHT_Z:    cfg_r.right[2]  <= cfg_data;
        REG_UP_X:       cfg_r.up[0]     <= cfg_data;
        REG_UP_Y:       cfg_r.up[1]     <= cfg_data;
        REG_UP_Z:       cfg_r.up[2]     <= cfg_data;
        REG_SIZE_SCALE: cfg_r.scale     <= cfg_data;
        REG_QUAD_MODE:  cfg_r.quad_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_spr.ctr[0] = in_center_x;
  assign in_spr.ctr[1] = in_center_y;
  assign in_spr.ctr[2] = in_center_z;
  assign in_spr.colour = in_sprite_colour;
  assign in_spr.last   = in_last_sprite;
  assign busy          = !in_ready;

  bbq_extent u_extent (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (start),
    .in_ready  (in_ready),
    .in_spr    (in_spr),
    .in_width  (in_sprite_width),
    .in_height (in_sprite_height),
    .out_valid (ext_valid),
    .out_ready (ext_ready),
    .out_ext   (ext)
  );

  bbq_corner u_corner (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ext_valid),
    .in_ready  (ext_ready),
    .in_ext    (ext),
    .out_valid (quad_valid),
    .out_ready (quad_ready),
    .out_quad  (quad)
  );

  bbq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .quad_mode (cfg_r.quad_mode),
    .in_valid  (quad_valid),
    .in_ready  (quad_ready),
    .in_quad   (quad),
    .out_valid (out_valid),
    .out_vert  (vert)
  );

  assign out_vert_x      = vert.x;
  assign out_vert_y      = vert.y;
  assign out_vert_z      = vert.z;
  assign out_tex_s       = vert.tex_s;
  assign out_tex_t       = vert.tex_t;
  assign out_vert_colour = vert.colour;
  assign out_corner      = vert.corner;
  assign out_sprite_done = vert.sprite_done;
  assign out_batch_done  = vert.batch_done;

endmodule
`default_nettype wire

// ----- rtl/bbq_extent.sv -----
`default_nettype none
// Stages 1 to 4: scaled half sizes, then the signed half extents a and b.
module bbq_extent import bbq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sprite_t           in_spr,
  input  wire logic [SIZE_W-1:0] in_width,
  input  wire logic [SIZE_W-1:0] in_height,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output extent_t                out_ext
);

  // floor shift of scale*size, clamped to 31 bits
  function automatic logic [HALF_W-1:0] half_size(input logic [SIZE_PROD_W-1:0] p);
    logic [SIZE_PROD_W-HALF_SHIFT-1:0] sh;
    sh = (SIZE_PROD_W-HALF_SHIFT)'(p >> HALF_SHIFT);
    if (sh > (SIZE_PROD_W-HALF_SHIFT)'({HALF_W{1'b1}})) begin
      return {HALF_W{1'b1}};
    end
    return sh[HALF_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] mag32(input logic [COORD_W-1:0] v);
    return v[COORD_W-1] ? -v : v;
  endfunction

  // truncate toward zero: shift the magnitude, then restore the sign
  function automatic ext_t signed_extent(input logic [EXT_PROD_W-1:0] p, input logic neg);
    logic [EXT_W-1:0] r;
    r = EXT_W'(p >> FRAC_BITS);
    return neg ? ext_t'(-r) : ext_t'(r);
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  sprite_t spr1_r, spr2_r, spr3_r;
  logic [SIZE_PROD_W-1:0] prod_w_r, prod_h_r;
  logic [HALF_W-1:0]      hw_r, hh_r;
  logic [EXT_PROD_W-1:0]  prod_a_r [3];
  logic [EXT_PROD_W-1:0]  prod_b_r [3];
  logic                   neg_a_r  [3];
  logic                   neg_b_r  [3];
  extent_t                ext_r;

  // stall chain: a stage moves when it is empty or its successor moves
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: size products
  always_ff @(posedge clk) begin
    if (rdy1) begin
      spr1_r   <= in_spr;
      prod_w_r <= SIZE_PROD_W'(cfg.scale) * SIZE_PROD_W'(in_width);
      prod_h_r <= SIZE_PROD_W'(cfg.scale) * SIZE_PROD_W'(in_height);
    end
  end

  // stage 2: half sizes
  always_ff @(posedge clk) begin
    if (rdy2) begin
      spr2_r <= spr1_r;
      hw_r   <= half_size(prod_w_r);
      hh_r   <= half_size(prod_h_r);
    end
  end

  // stage 3: half size times vector magnitude, one lane per component
  always_ff @(posedge clk) begin
    if (rdy3) begin
      spr3_r <= spr2_r;
      for (int c = 0; c < 3; c++) begin
        prod_a_r[c] <= EXT_PROD_W'(hw_r) * EXT_PROD_W'(mag32(cfg.right[c]));
        prod_b_r[c] <= EXT_PROD_W'(hh_r) * EXT_PROD_W'(mag32(cfg.up[c]));
        neg_a_r[c]  <= cfg.right[c][COORD_W-1];
        neg_b_r[c]  <= cfg.up[c][COORD_W-1];
      end
    end
  end

  // stage 4: signed extents
  always_ff @(posedge clk) begin
    if (rdy4) begin
      ext_r.spr <= spr3_r;
      for (int c = 0; c < 3; c++) begin
        ext_r.a[c] <= signed_extent(prod_a_r[c], neg_a_r[c]);
        ext_r.b[c] <= signed_extent(prod_b_r[c], neg_b_r[c]);
      end
    end
  end

  assign out_valid = v4_r;
  assign out_ext   = ext_r;

endmodule
`default_nettype wire

// ----- rtl/bbq_corner.sv -----
`default_nettype none
// Stages 5 and 6: corner positions, then scaling and clamping to 16 bits.
module bbq_corner import bbq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire extent_t in_ext,
  output logic         out_valid,
  input  wire logic    out_ready,
  output quad_t        out_quad
);

  typedef logic signed [POS_W-1:0] pos_t;

  // p * 64 / 2^FRAC_BITS toward zero, saturated
  function automatic vout_t to_out(input pos_t p);
    logic [POS_W-1:0] m;
    logic [POS_W-1:0] r;
    m = p[POS_W-1] ? -p : p;
    r = m >> OUT_SHIFT;
    if (p[POS_W-1]) begin
      if (r > POS_W'(2 ** (OUT_W - 1))) return vout_t'({1'b1, {(OUT_W-1){1'b0}}});
      return vout_t'(-r[OUT_W-1:0]);
    end
    if (r > POS_W'(2 ** (OUT_W - 1) - 1)) return vout_t'({1'b0, {(OUT_W-1){1'b1}}});
    return vout_t'(r[OUT_W-1:0]);
  endfunction

  logic v5_r, v6_r;
  logic rdy5, rdy6;

  sprite_t spr5_r;
  pos_t    pos_r [4][3];
  pos_t    cw [3];
  pos_t    aw [3];
  pos_t    bw [3];
  quad_t   quad_r;

  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign in_ready = rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy5) v5_r <= in_valid;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // sign extension of the terms
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cw[c] = POS_W'($signed(in_ext.spr.ctr[c]));
      aw[c] = POS_W'($signed(in_ext.a[c]));
      bw[c] = POS_W'($signed(in_ext.b[c]));
    end
  end

  // stage 5: corners in order +a+b, -a+b, -a-b, +a-b
  always_ff @(posedge clk) begin
    if (rdy5) begin
      spr5_r <= in_ext.spr;
      for (int c = 0; c < 3; c++) begin
        pos_r[0][c] <= cw[c] + aw[c] + bw[c];
        pos_r[1][c] <= cw[c] - aw[c] + bw[c];
        pos_r[2][c] <= cw[c] - aw[c] - bw[c];
        pos_r[3][c] <= cw[c] + aw[c] - bw[c];
      end
    end
  end

  // stage 6: output format
  always_ff @(posedge clk) begin
    if (rdy6) begin
      quad_r.spr <= spr5_r;
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          quad_r.pos[k][c] <= to_out(pos_r[k][c]);
        end
      end
    end
  end

  assign out_valid = v6_r;
  assign out_quad  = quad_r;

endmodule
`default_nettype wire

// ----- rtl/bbq_emit.sv -----
`default_nettype none
// Vertex sequencer: holds one finished quad and sends one vertex per cycle.
module bbq_emit import bbq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  quad_mode,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire quad_t in_quad,
  output logic       out_valid,
  output vert_t      out_vert
);

  logic              em_valid_r, em_valid_nxt;
  logic [VCNT_W-1:0] em_cnt_r, em_cnt_nxt;
  logic              em_quad_r;
  quad_t             em_data_r;

  logic       em_final;
  logic       load;
  logic [1:0] cn;

  assign em_final = em_cnt_r == (em_quad_r ? LAST_QUAD : LAST_TRI);
  // a new quad may be taken during the final vertex of the current one
  assign in_ready = !em_valid_r || em_final;
  assign load     = in_valid && in_ready;

  always_comb begin
    em_valid_nxt = em_valid_r;
    em_cnt_nxt   = em_cnt_r;
    if (load) begin
      em_valid_nxt = 1'b1;
      em_cnt_nxt   = '0;
    end else if (em_valid_r) begin
      if (em_final) begin
        em_valid_nxt = 1'b0;
      end else begin
        em_cnt_nxt = em_cnt_r + VCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      em_cnt_r   <= '0;
    end else begin
      em_valid_r <= em_valid_nxt;
      em_cnt_r   <= em_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      em_data_r <= in_quad;
      em_quad_r <= quad_mode;
    end
  end

  // corner selection and per-vertex fields
  assign cn = em_quad_r ? em_cnt_r[1:0] : tri_corner(em_cnt_r);

  always_comb begin
    out_vert.x           = em_data_r.pos[cn][0];
    out_vert.y           = em_data_r.pos[cn][1];
    out_vert.z           = em_data_r.pos[cn][2];
    out_vert.tex_s       = (cn == 2'd0 || cn == 2'd3) ? TEX_ONE : '0;
    out_vert.tex_t       = cn[1] ? TEX_ONE : '0;
    out_vert.colour      = em_data_r.spr.colour;
    out_vert.corner      = cn;
    out_vert.sprite_done = em_final;
    out_vert.batch_done  = em_final && em_data_r.spr.last;
  end

  assign out_valid = em_valid_r;

endmodule
`default_nettype wire

// ----- tb/sv/billboard_quad_vertex_expander_tb.sv -----
module billboard_quad_vertex_expander_tb;
  import bbq_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int TIMEOUT_CYCLES = 100000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_GAP        = 13;
  localparam int REG_COUNT      = 8;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_SPRITES  = 40;

  // triangle list walks corners 0,1,2,0,2,3; texcoord bits indexed by corner
  localparam logic [5:0][1:0] TRI_SEQ  = {2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
  localparam logic [3:0]      CORNER_S = 4'b1001;
  localparam logic [3:0]      CORNER_T = 4'b1100;

  typedef logic [REG_COUNT-1:0][COORD_W-1:0] reg_file_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] centre;
    logic [SIZE_W-1:0]       width;
    logic [SIZE_W-1:0]       height;
    logic [COLOUR_W-1:0]     colour;
    logic                    last;
  } sprite_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [COORD_W-1:0]    cfg_data;
  logic                  start;
  logic                  busy;
  logic [COORD_W-1:0]    in_center_x;
  logic [COORD_W-1:0]    in_center_y;
  logic [COORD_W-1:0]    in_center_z;
  logic [SIZE_W-1:0]     in_sprite_width;
  logic [SIZE_W-1:0]     in_sprite_height;
  logic [COLOUR_W-1:0]   in_sprite_colour;
  logic                  in_last_sprite;
  logic                  out_valid;
  logic signed [OUT_W-1:0] out_vert_x;
  logic signed [OUT_W-1:0] out_vert_y;
  logic signed [OUT_W-1:0] out_vert_z;
  logic [TEX_W-1:0]      out_tex_s;
  logic [TEX_W-1:0]      out_tex_t;
  logic [COLOUR_W-1:0]   out_vert_colour;
  logic [1:0]            out_corner;
  logic                  out_sprite_done;
  logic                  out_batch_done;

  // shadow of the register file and the vertices still owed by the block
  reg_file_t   shadow_regs;
  vert_t       expected_verts[$];
  bit          burst_mode;
  int          mismatches;
  int          sprites_sent;
  int          tri_sprites;
  int          verts_checked;
  int          reg_settings;

  billboard_quad_vertex_expander DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_center_z      (in_center_z),
    .in_sprite_width  (in_sprite_width),
    .in_sprite_height (in_sprite_height),
    .in_sprite_colour (in_sprite_colour),
    .in_last_sprite   (in_last_sprite),
    .out_valid        (out_valid),
    .out_vert_x       (out_vert_x),
    .out_vert_y       (out_vert_y),
    .out_vert_z       (out_vert_z),
    .out_tex_s        (out_tex_s),
    .out_tex_t        (out_tex_t),
    .out_vert_colour  (out_vert_colour),
    .out_corner       (out_corner),
    .out_sprite_done  (out_sprite_done),
    .out_batch_done   (out_batch_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed point predictor
  // ---------------------------------------------------------------------------

  function automatic reg_file_t default_regs();
    reg_file_t r;
    r = '0;
    r[REG_RIGHT_X]    = COORD_W'(1) << FRAC_BITS;
    r[REG_UP_Y]       = COORD_W'(1) << FRAC_BITS;
    r[REG_SIZE_SCALE] = COORD_W'(1) << FRAC_BITS;
    r[REG_QUAD_MODE]  = COORD_W'(1);
    return r;
  endfunction

  // scale * size / 2, floored, clamped to 31 bits
  function automatic logic [30:0] scaled_half(logic [31:0] scale, logic [SIZE_W-1:0] size);
    logic [63:0] prod;
    prod = (64'(scale) * 64'(size)) >> (FRAC_BITS + 1);
    return (prod > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : prod[30:0];
  endfunction

  // half size times one vector component, truncated toward zero
  function automatic logic signed [63:0] axis_extent(logic [30:0] half, logic [31:0] comp);
    logic signed [63:0] sc;
    logic [63:0]        mag;
    logic [63:0]        r;
    sc  = $signed(comp);
    mag = (sc < 0) ? -sc : sc;
    r   = (64'(half) * mag) >> FRAC_BITS;
    return (sc < 0) ? -$signed(r) : $signed(r);
  endfunction

  // position times 64, truncated toward zero, saturated to 16 bits
  function automatic vout_t vertex_coord(logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = (p < 0) ? -p : p;
    r   = (mag * 64'd64) >> FRAC_BITS;
    if (p < 0)
      return (r > 64'd32768) ? vout_t'(16'h8000) : vout_t'(-r);
    return (r > 64'd32767) ? vout_t'(16'h7FFF) : vout_t'(r);
  endfunction

  // queue up every vertex one sprite transfer produces
  task automatic expand_sprite(sprite_req_t s);
    logic [30:0]        half_w;
    logic [30:0]        half_h;
    logic signed [63:0] ctr;
    logic signed [63:0] ext_a;
    logic signed [63:0] ext_b;
    logic signed [63:0] corner_pos [4][3];
    int                 nverts;
    logic [1:0]         cn;
    vert_t              v;
    half_w = scaled_half(shadow_regs[REG_SIZE_SCALE], s.width);
    half_h = scaled_half(shadow_regs[REG_SIZE_SCALE], s.height);
    for (int c = 0; c < 3; c++) begin
      ctr   = $signed(s.centre[c]);
      ext_a = axis_extent(half_w, shadow_regs[int'(REG_RIGHT_X) + c]);
      ext_b = axis_extent(half_h, shadow_regs[int'(REG_UP_X) + c]);
      corner_pos[0][c] = ctr + ext_a + ext_b;
      corner_pos[1][c] = ctr - ext_a + ext_b;
      corner_pos[2][c] = ctr - ext_a - ext_b;
      corner_pos[3][c] = ctr + ext_a - ext_b;
    end
    nverts = shadow_regs[REG_QUAD_MODE][0] ? 4 : 6;
    if (nverts == 6) tri_sprites++;
    for (int k = 0; k < nverts; k++) begin
      cn            = (nverts == 4) ? 2'(k) : TRI_SEQ[k];
      v.x           = vertex_coord(corner_pos[cn][0]);
      v.y           = vertex_coord(corner_pos[cn][1]);
      v.z           = vertex_coord(corner_pos[cn][2]);
      v.tex_s       = CORNER_S[cn] ? TEX_ONE : '0;
      v.tex_t       = CORNER_T[cn] ? TEX_ONE : '0;
      v.colour      = s.colour;
      v.corner      = cn;
      v.sprite_done = (k == nverts - 1);
      v.batch_done  = (k == nverts - 1) && s.last;
      expected_verts.push_back(v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Vertex checker: one result per out_valid cycle, sampled mid-cycle
  // ---------------------------------------------------------------------------

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin : vertex_check
    vert_t w;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_verts.size() == 0) begin
        $error("vertex transfer with no vertex outstanding");
        mismatches++;
      end else begin
        w = expected_verts.pop_front();
        report_field("vert_x",      w.x,           out_vert_x);
        report_field("vert_y",      w.y,           out_vert_y);
        report_field("vert_z",      w.z,           out_vert_z);
        report_field("tex_s",       w.tex_s,       out_tex_s);
        report_field("tex_t",       w.tex_t,       out_tex_t);
        report_field("vert_colour", w.colour,      out_vert_colour);
        report_field("corner",      w.corner,      out_corner);
        report_field("sprite_done", w.sprite_done, out_sprite_done);
        report_field("batch_done",  w.batch_done,  out_batch_done);
        verts_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // one sprite transfer; start is left high so back-to-back sprites stay packed
  task automatic send_sprite(sprite_req_t s);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_center_x      <= s.centre[0];
    in_center_y      <= s.centre[1];
    in_center_z      <= s.centre[2];
    in_sprite_width  <= s.width;
    in_sprite_height <= s.height;
    in_sprite_colour <= s.colour;
    in_last_sprite   <= s.last;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    expand_sprite(s);
    sprites_sent++;
  endtask

  // block is idle once every owed vertex has come out and busy is low
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_verts.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_QUAD_MODE)
      shadow_regs[idx] = {31'b0, data[0]};
    else if (idx < REG_COUNT)
      shadow_regs[idx] = data;
  endtask

  // full register load, followed by junk to the unmapped indexes
  task automatic program_regs(reg_file_t vals);
    wait_idle();
    for (int i = 0; i < REG_COUNT; i++)
      write_reg(IDX_W'(i), vals[i]);
    for (int i = REG_COUNT; i < 2 ** IDX_W; i++)
      write_reg(IDX_W'(i), $urandom);
    cfg_we <= 1'b0;
    reg_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sprite_req_t make_sprite(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] cz, logic [30:0] w,
                                              logic [30:0] h, logic [31:0] colour,
                                              logic last);
    sprite_req_t s;
    s.centre = {cz, cy, cx};
    s.width  = w;
    s.height = h;
    s.colour = colour;
    s.last   = last;
    return s;
  endfunction

  // signed word spread over all magnitudes, with the extremes now and then
  function automatic logic [31:0] rand_signed_word();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = '0;
      3, 4:    ;
      default: v = $signed(v) >>> $urandom_range(1, 31);
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rand_size();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0:       v = 32'h7FFF_FFFF;
      1:       v = '0;
      2:       ;
      default: v = v >> $urandom_range(8, 31);
    endcase
    return v[30:0];
  endfunction

  function automatic sprite_req_t rand_sprite();
    return make_sprite(rand_signed_word(), rand_signed_word(), rand_signed_word(),
                       rand_size(), rand_size(), $urandom,
                       $urandom_range(0, 3) == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values: unit right/up vectors, unit scale, quads
  task automatic test_reset_defaults();
    send_sprite(make_sprite('0, '0, '0, '0, '0, '0, 1'b0));
    send_sprite(make_sprite(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000,
                            31'h0002_0000, 31'h0004_0000, 32'hFFFF_FFFF, 1'b1));
    send_sprite(make_sprite(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hA5A5_A5A5, 1'b0));
    send_sprite(make_sprite(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b1));
    // tiny negatives truncate toward zero
    send_sprite(make_sprite(32'hFFFF_FFFF, 32'hFFFF_FC01, 32'h0000_03FF,
                            31'h1, 31'h1, 32'h0000_0001, 1'b0));
  endtask

  // saturating vectors and scales, both output modes
  task automatic test_extreme_config();
    reg_file_t r;
    r = '0;
    r[REG_RIGHT_X]    = 32'h7FFF_FFFF;
    r[REG_RIGHT_Y]    = 32'h8000_0000;
    r[REG_RIGHT_Z]    = 32'hFFFF_FFFF;
    r[REG_UP_X]       = 32'h8000_0000;
    r[REG_UP_Y]       = 32'h7FFF_FFFF;
    r[REG_UP_Z]       = 32'h0000_0001;
    r[REG_SIZE_SCALE] = 32'hFFFF_FFFF;
    r[REG_QUAD_MODE]  = 32'h0;
    program_regs(r);
    send_sprite(make_sprite('0, '0, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h1234_5678, 1'b1));
    send_sprite(make_sprite(32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 31'h1, '0, 1'b0));
    send_sprite(make_sprite('0, '0, '0, 31'h0000_0100, 31'h0000_0010, '1, 1'b0));
    send_sprite(make_sprite(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                            31'h1, 31'h7FFF_FFFF, 32'h8000_0001, 1'b1));
    r[REG_RIGHT_X]    = 32'h8000_0000;
    r[REG_RIGHT_Y]    = 32'h8000_0000;
    r[REG_RIGHT_Z]    = 32'h8000_0000;
    r[REG_UP_X]       = 32'h7FFF_FFFF;
    r[REG_UP_Y]       = 32'h7FFF_FFFF;
    r[REG_UP_Z]       = 32'h7FFF_FFFF;
    r[REG_SIZE_SCALE] = 32'h0;
    r[REG_QUAD_MODE]  = 32'h1;
    program_regs(r);
    send_sprite(make_sprite(32'h0100_0000, 32'hFF00_0000, 32'h0000_0400,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hDEAD_BEEF, 1'b1));
    send_sprite(make_sprite('0, '0, '0, 31'h7FFF_FFFF, '0, 32'h0F0F_0F0F, 1'b0));
  endtask

  // only bit 0 of quad_mode matters; unmapped indexes must not disturb anything
  task automatic test_mode_bit_and_index();
    reg_file_t r;
    r = default_regs();
    r[REG_QUAD_MODE] = 32'hFFFF_FFFE;
    program_regs(r);
    send_sprite(make_sprite(32'h0001_8000, 32'hFFFE_8000, '0,
                            31'h0003_0000, 31'h0001_0000, 32'hCAFE_F00D, 1'b0));
    send_sprite(make_sprite('0, '0, 32'h0000_4000, 31'h0000_8000, 31'h0000_8000,
                            32'h0000_FFFF, 1'b1));
    r[REG_QUAD_MODE] = 32'h8000_0001;
    program_regs(r);
    send_sprite(make_sprite(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000,
                            31'h0001_0000, 31'h0002_0000, 32'hFFFF_0000, 1'b1));
    send_sprite(make_sprite(32'h0000_0400, 32'hFFFF_FC00, '0, 31'h0000_0800,
                            31'h0000_0800, 32'h1111_2222, 1'b0));
  endtask

  // random register settings, each followed by a run of random sprites
  task automatic test_random_phases();
    reg_file_t r;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r[REG_RIGHT_X]    = rand_signed_word();
      r[REG_RIGHT_Y]    = rand_signed_word();
      r[REG_RIGHT_Z]    = rand_signed_word();
      r[REG_UP_X]       = rand_signed_word();
      r[REG_UP_Y]       = rand_signed_word();
      r[REG_UP_Z]       = rand_signed_word();
      r[REG_SIZE_SCALE] = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF
                                                      : $urandom >> $urandom_range(8, 24);
      r[REG_QUAD_MODE]  = $urandom;
      program_regs(r);
      burst_mode = (ph % 3 == 2);
      for (int i = 0; i < PHASE_SPRITES; i++)
        send_sprite(rand_sprite());
      burst_mode = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    start            <= 1'b0;
    in_center_x      <= '0;
    in_center_y      <= '0;
    in_center_z      <= '0;
    in_sprite_width  <= '0;
    in_sprite_height <= '0;
    in_sprite_colour <= '0;
    in_last_sprite   <= 1'b0;
    shadow_regs   = default_regs();
    burst_mode    = 1'b0;
    mismatches    = 0;
    sprites_sent  = 0;
    tri_sprites   = 0;
    verts_checked = 0;
    reg_settings  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extreme_config();
    test_mode_bit_and_index();
    test_random_phases();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_verts.size() != 0) begin
      $error("%0d vertices never came out", expected_verts.size());
      mismatches++;
    end
    $display("Expanded %0d sprites (%0d as triangle lists) under %0d register loads;",
             sprites_sent, tri_sprites, reg_settings);
    $display("%0d vertices compared, %0d field mismatches.", verts_checked, mismatches);
    if (mismatches == 0)
      $display("[billboard_quad_vertex_expander] OK");
    else
      $display("[billboard_quad_vertex_expander] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Run stopped by the watchdog");
    $display("[billboard_quad_vertex_expander] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bbq_pkg.sv
rtl/bbq_extent.sv
rtl/bbq_corner.sv
rtl/bbq_emit.sv
rtl/billboard_quad_vertex_expander.sv
tb/sv/billboard_quad_vertex_expander_tb.sv
